FILE: design/cubic_bezier_path_point_macros.svh
// Assertion macros for the cubic Bezier path point evaluator.
// Self-contained; included by the top level only.
`ifndef CUBIC_BEZIER_PATH_POINT_MACROS_SVH
`define CUBIC_BEZIER_PATH_POINT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CBPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbpp assertion failed");

// Next-cycle implication, disabled during reset
`define CBPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbpp assertion failed");

`endif

FILE: design/cbpp_pkg.sv
// Shared types and constants for the cubic Bezier path point evaluator.
// No dependencies.
package cbpp_pkg;

  // Item kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  // Field widths
  localparam int COORD_W = 32;
  localparam int T_W     = 17;
  localparam int CNT_W   = 7;
  localparam int SEG_W   = 6;
  localparam int PIDX_W  = 8;

  // Fixed-point constants
  localparam logic [T_W-1:0] ONE_Q16 = 17'h1_0000;
  localparam int WEIGHT_W = 49;       // each weight is at most 2^48
  localparam int WSPLIT   = 24;       // weight split point for the multipliers
  localparam int ACC_W    = 60;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [3*COORD_W-1:0]      point_t;

endpackage

FILE: design/cubic_bezier_path_point.sv
// Cubic Bezier path point: a write item is stored as it is accepted. An evaluate item makes
// four one-per-cycle reads of the single-port point memory, then passes the weight, product,
// accumulate and output registers; no new item is taken until its result enters the output
// register, which waits while a result is unaccepted; an out-of-range one skips the reads.
// Synchronous active-low reset clears the control flags and segment count; the point memory
// is not cleared and holds undefined data until written.
`include "cubic_bezier_path_point_macros.svh"

module cubic_bezier_path_point
  import cbpp_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic [CNT_W-1:0]         cfg_wr_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  logic [PIDX_W-1:0]        in_point_index,
  input  logic [SEG_W-1:0]         in_segment_index,
  input  logic [T_W-1:0]           in_t_param,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic signed [COORD_W-1:0] in_z,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic                     out_of_range
);

  localparam int StoreDepth = 3 * MAX_SEGMENTS + 1;
  localparam int AddrW      = $clog2(StoreDepth);

  // ---------------------------------------------------------------- control
  logic             seg_cnt_nz;
  logic [CNT_W-1:0] seg_cnt_r;
  logic             busy_r;
  logic             issue_r;
  logic [1:0]       rd_k_r;
  logic             rdv_r, wv_r, pv_r, fin_v_r;
  logic [1:0]       rdk_r, wk_r, pk_r;
  logic             oor_r;
  logic             out_valid_r;

  logic             in_xfer, eval_xfer, wr_xfer, seg_ok, out_load;

  assign in_ready  = !busy_r;
  assign in_xfer   = in_valid && in_ready;
  assign eval_xfer = in_xfer && (in_action == ACT_EVAL);
  assign wr_xfer   = in_xfer && (in_action == ACT_WRITE)
                     && (int'(in_point_index) < StoreDepth);
  assign seg_ok    = (int'(in_segment_index) < int'(seg_cnt_r))
                     && (int'(in_segment_index) < MAX_SEGMENTS);
  assign out_load  = fin_v_r && (!out_valid_r || out_ready);

  // Segment count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r <= '0;
    end else if (cfg_wr_en) begin
      seg_cnt_r <= cfg_wr_data;
    end
  end
  assign seg_cnt_nz = |seg_cnt_r;

  // ---------------------------------------------------------- item latching
  logic [T_W-1:0]   t_r, u_r;
  logic [T_W-1:0]   t_clamp;
  logic [AddrW-1:0] base_r;

  assign t_clamp = (in_t_param > ONE_Q16) ? ONE_Q16 : in_t_param;

  always_ff @(posedge clk) begin
    if (eval_xfer) begin
      t_r    <= t_clamp;
      u_r    <= ONE_Q16 - t_clamp;
      base_r <= AddrW'(int'(in_segment_index) * 3);
    end
  end

  // Sequencer flags: read issue, then weight, product, accumulate, output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      issue_r     <= 1'b0;
      rd_k_r      <= '0;
      rdv_r       <= 1'b0;
      wv_r        <= 1'b0;
      pv_r        <= 1'b0;
      fin_v_r     <= 1'b0;
      oor_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rdv_r <= issue_r;
      wv_r  <= rdv_r;
      pv_r  <= wv_r;

      if (eval_xfer) begin
        busy_r  <= 1'b1;
        oor_r   <= !seg_ok;
        issue_r <= seg_ok;
        rd_k_r  <= '0;
        fin_v_r <= !seg_ok;
      end else begin
        if (issue_r) begin
          rd_k_r <= rd_k_r + 2'd1;
          if (rd_k_r == 2'd3) begin
            issue_r <= 1'b0;
          end
        end
        if (pv_r && (pk_r == 2'd3)) begin
          fin_v_r <= 1'b1;
        end else if (out_load) begin
          fin_v_r <= 1'b0;
          busy_r  <= 1'b0;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Point index follows its data down the pipe
  always_ff @(posedge clk) begin
    rdk_r <= rd_k_r;
    wk_r  <= rdk_r;
    pk_r  <= wk_r;
  end

  // ---------------------------------------------------------- point memory
  // Single port: writes only while idle; the control point reads are issued only while busy.
  point_t           point_mem [StoreDepth];
  point_t           rd_data_r;
  logic [AddrW-1:0] mem_addr;

  assign mem_addr = issue_r ? (base_r + AddrW'(rd_k_r)) : AddrW'(in_point_index);

  always_ff @(posedge clk) begin
    if (wr_xfer) begin
      point_mem[mem_addr] <= {in_z, in_y, in_x};
    end
    rd_data_r <= point_mem[mem_addr];
  end

  // ------------------------------------------------------------ weights
  // Squares first, then one product per point: u^3, 3u^2 t, 3u t^2, t^3.
  logic [2*T_W-1:0]      u2_r, t2_r;
  logic [2*T_W-1:0]      wa;
  logic [T_W-1:0]        wb;
  logic [3*T_W-1:0]      wprod, wscaled;
  logic [WEIGHT_W-1:0]   w_r;
  coord_t                pt_r [3];

  always_ff @(posedge clk) begin
    u2_r <= u_r * u_r;
    t2_r <= t_r * t_r;
  end

  assign wa      = rdk_r[1] ? t2_r : u2_r;
  assign wb      = ((rdk_r == 2'd0) || (rdk_r == 2'd2)) ? u_r : t_r;
  assign wprod   = wa * wb;
  assign wscaled = (rdk_r == 2'd1 || rdk_r == 2'd2) ? (wprod + {wprod[3*T_W-2:0], 1'b0})
                                                     : wprod;

  always_ff @(posedge clk) begin
    w_r      <= wscaled[WEIGHT_W-1:0];
    pt_r[0]  <= rd_data_r[COORD_W-1:0];
    pt_r[1]  <= rd_data_r[2*COORD_W-1:COORD_W];
    pt_r[2]  <= rd_data_r[3*COORD_W-1:2*COORD_W];
  end

  // ---------------------------------------------------- products per lane
  // Weight split in two halves so each multiplier stays near 32 bits.
  logic signed [WEIGHT_W-WSPLIT+COORD_W:0] ph_r [3];
  logic signed [WSPLIT+COORD_W:0]          pl_r [3];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      ph_r[c] <= $signed({1'b0, w_r[WEIGHT_W-1:WSPLIT]}) * pt_r[c];
      pl_r[c] <= $signed({1'b0, w_r[WSPLIT-1:0]}) * pt_r[c];
    end
  end

  // ---------------------------------------------------------- accumulate
  logic signed [ACC_W-1:0] acc_hi_r [3];
  logic signed [ACC_W-1:0] acc_lo_r [3];

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (eval_xfer) begin
        acc_hi_r[c] <= '0;
        acc_lo_r[c] <= '0;
      end else if (pv_r) begin
        acc_hi_r[c] <= acc_hi_r[c] + ACC_W'(ph_r[c]);
        acc_lo_r[c] <= acc_lo_r[c] + ACC_W'(pl_r[c]);
      end
    end
  end

  // ------------------------------------------------ round, saturate, output
  // floor((hi*2^24 + lo + 2^47) / 2^48) then clamp to 32 bits
  logic signed [ACC_W-1:0]        rsum [3];
  logic signed [ACC_W-WSPLIT-1:0] rnd  [3];
  coord_t                         sat  [3];
  coord_t                         res_r [3];
  logic                           res_oor_r;

  localparam logic signed [ACC_W-WSPLIT-1:0] SatMax = (ACC_W-WSPLIT)'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-WSPLIT-1:0] SatMin = -(ACC_W-WSPLIT)'(33'sh0_8000_0000);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rsum[c] = acc_hi_r[c] + (acc_lo_r[c] >>> WSPLIT) + (ACC_W'(1) <<< (WSPLIT - 1));
      rnd[c]  = rsum[c][ACC_W-1:WSPLIT];
      priority if (oor_r) begin
        sat[c] = '0;
      end else if (rnd[c] > SatMax) begin
        sat[c] = coord_t'(SatMax);
      end else if (rnd[c] < SatMin) begin
        sat[c] = coord_t'(SatMin);
      end else begin
        sat[c] = coord_t'(rnd[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int c = 0; c < 3; c++) begin
        res_r[c] <= sat[c];
      end
      res_oor_r <= oor_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_x        = res_r[0];
  assign out_y        = res_r[1];
  assign out_z        = res_r[2];
  assign out_of_range = res_oor_r;

  // ------------------------------------------------------------ assertions
  `CBPP_ASSERT_NOW(a_no_write_during_read, clk, rst_n, wr_xfer, !issue_r)
  `CBPP_ASSERT_NOW(a_oor_zero, clk, rst_n, out_valid && out_of_range, (out_x | out_y | out_z) == 0)
  `CBPP_ASSERT_NEXT(a_eval_blocks_input, clk, rst_n, eval_xfer, !in_ready)
  `CBPP_ASSERT_NOW(a_reads_only_when_busy, clk, rst_n, issue_r || rdv_r || wv_r || pv_r, busy_r && !oor_r && seg_cnt_nz)

endmodule

FILE: tb/sv/bezier_point_checker.sv
// Checker for the cubic Bezier path point evaluator: watches both channels and the
// configuration port, predicts each curve point and compares it field by field.
// Depends on cbpp_pkg.
`timescale 1ns / 100ps

module bezier_point_checker
  import cbpp_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CNT_W-1:0]          cfg_wr_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_action,
  input  logic [PIDX_W-1:0]         in_point_index,
  input  logic [SEG_W-1:0]          in_segment_index,
  input  logic [T_W-1:0]            in_t_param,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic signed [COORD_W-1:0] in_z,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [COORD_W-1:0] out_x,
  input  logic signed [COORD_W-1:0] out_y,
  input  logic signed [COORD_W-1:0] out_z,
  input  logic                      out_of_range,
  output int                        mismatches,
  output int                        points_due
);

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } ctrl_pt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   oor;
  } curve_pt_t;

  // Own copy of the point store and the segment count
  ctrl_pt_t         ctrl_pts [0:3*MAX_SEGMENTS];
  logic [CNT_W-1:0] seg_count;
  curve_pt_t        points_ahead [$];

  // One coordinate of the curve point: exact weighted sum, round half up, saturate
  function automatic coord_t blend_axis(input logic [T_W-1:0] t, input coord_t p0,
                                        input coord_t p1, input coord_t p2, input coord_t p3);
    logic signed [95:0] tw;
    logic signed [95:0] uw;
    logic signed [95:0] acc;
    tw  = (t > ONE_Q16) ? ONE_Q16 : t;
    uw  = ONE_Q16 - tw;
    acc = uw * uw * uw * p0 + 3 * uw * uw * tw * p1
        + 3 * uw * tw * tw * p2 + tw * tw * tw * p3;
    acc = (acc + (96'sd1 <<< 47)) >>> 48;
    if (acc > 96'sd2147483647)
      acc = 96'sd2147483647;
    else if (acc < -96'sd2147483648)
      acc = -96'sd2147483648;
    return acc[COORD_W-1:0];
  endfunction

  task automatic flag_field(input string name, input logic signed [31:0] want,
                            input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    curve_pt_t due;
    int        eff;
    int        b;
    if (!rst_n) begin
      seg_count = '0;
      points_ahead.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en)
        seg_count = cfg_wr_data;

      // result transfer: compare with the oldest prediction
      if (out_valid && out_ready) begin
        if (points_ahead.size() == 0) begin
          $display("%0t ns: unexpected result x=%0d y=%0d z=%0d out_of_range=%0b",
                   $time, out_x, out_y, out_z, out_of_range);
          mismatches++;
        end else begin
          due = points_ahead.pop_front();
          flag_field("out_x", due.x, out_x);
          flag_field("out_y", due.y, out_y);
          flag_field("out_z", due.z, out_z);
          flag_field("out_of_range", due.oor, out_of_range);
        end
      end

      // input transfer: store a point or predict a curve point
      if (in_valid && in_ready) begin
        if (in_action == ACT_WRITE) begin
          if (in_point_index <= 3 * MAX_SEGMENTS)
            ctrl_pts[in_point_index] = '{x: in_x, y: in_y, z: in_z};
        end else begin
          eff = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_count;
          due = '0;
          if (in_segment_index >= eff) begin
            due.oor = 1'b1;
          end else begin
            b = 3 * in_segment_index;
            due.x = blend_axis(in_t_param, ctrl_pts[b].x, ctrl_pts[b+1].x,
                               ctrl_pts[b+2].x, ctrl_pts[b+3].x);
            due.y = blend_axis(in_t_param, ctrl_pts[b].y, ctrl_pts[b+1].y,
                               ctrl_pts[b+2].y, ctrl_pts[b+3].y);
            due.z = blend_axis(in_t_param, ctrl_pts[b].z, ctrl_pts[b+1].z,
                               ctrl_pts[b+2].z, ctrl_pts[b+3].z);
          end
          points_ahead.insert(points_ahead.size(), due);
        end
      end
    end
    points_due = points_ahead.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Top of the cubic Bezier path point testbench: clock, reset, stimulus and verdict.
// Depends on cbpp_pkg, cubic_bezier_path_point and bezier_point_checker.
`timescale 1ns / 100ps

module tb;
  import cbpp_pkg::*;

  localparam int     NUM_SEGS  = 64;
  localparam int     LAST_SLOT = 3 * NUM_SEGS;
  localparam coord_t C_MAX     = 32'sh7FFF_FFFF;
  localparam coord_t C_MIN     = 32'sh8000_0000;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [CNT_W-1:0]          cfg_wr_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_action;
  logic [PIDX_W-1:0]         in_point_index;
  logic [SEG_W-1:0]          in_segment_index;
  logic [T_W-1:0]            in_t_param;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;
  logic signed [COORD_W-1:0] in_z;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      out_of_range;
  int                        mismatches;
  int                        points_due;

  // Slots written so far, so no segment with an unwritten point is evaluated
  bit loaded [0:LAST_SLOT];
  int cur_count;
  bit tx_steady;
  bit rx_steady;

  cubic_bezier_path_point #(.MAX_SEGMENTS(NUM_SEGS)) dut (.*);

  bezier_point_checker #(.MAX_SEGMENTS(NUM_SEGS)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #(600_000 * 20);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic coord_t random_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2)
      return C_MAX;
    else if (r < 4)
      return C_MIN;
    else if (r == 4)
      return '0;
    else if (r == 5)
      return -32'sd1;
    else if (r < 11)
      return $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
    return $urandom;
  endfunction

  function automatic logic [T_W-1:0] random_t();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return '0;
    else if (r == 1)
      return ONE_Q16;
    else if (r == 2)
      return T_W'($urandom_range(65537, 131071));
    return T_W'($urandom_range(0, 65536));
  endfunction

  function automatic bit seg_ready(input int seg);
    return loaded[3*seg] && loaded[3*seg+1] && loaded[3*seg+2] && loaded[3*seg+3];
  endfunction

  // One input transfer; fields the action does not use still carry random bits
  task automatic send_item(input logic act, input logic [PIDX_W-1:0] pidx,
                           input logic [SEG_W-1:0] seg, input logic [T_W-1:0] t,
                           input coord_t x, input coord_t y, input coord_t z);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action        = act;
    in_point_index   = pidx;
    in_segment_index = seg;
    in_t_param       = t;
    in_x             = x;
    in_y             = y;
    in_z             = z;
    in_valid         = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (act == ACT_WRITE && pidx <= LAST_SLOT)
      loaded[pidx] = 1'b1;
  endtask

  task automatic write_point(input int pidx, input coord_t x, input coord_t y, input coord_t z);
    send_item(ACT_WRITE, PIDX_W'(pidx), SEG_W'($urandom), T_W'($urandom), x, y, z);
  endtask

  task automatic eval_curve(input int seg, input logic [T_W-1:0] t);
    send_item(ACT_EVAL, PIDX_W'($urandom), SEG_W'(seg), t, $urandom, $urandom, $urandom);
  endtask

  // Stop offering, wait for every curve point, then let the pipeline drain
  task automatic settle(input int extra);
    in_valid = 1'b0;
    while (points_due != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic load_count(input int v);
    settle(16);
    cfg_wr_data = CNT_W'(v);
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cur_count   = v;
  endtask

  // Mostly evaluations; a segment not yet filled gets its next missing point instead
  task automatic random_item();
    int r;
    int eff;
    int seg;
    int k;
    r   = $urandom_range(0, 99);
    eff = (cur_count > NUM_SEGS) ? NUM_SEGS : cur_count;
    if (r < 35) begin
      if ($urandom_range(0, 9) == 0)
        k = $urandom_range(0, 255);
      else
        k = $urandom_range(0, LAST_SLOT);
      write_point(k, random_coord(), random_coord(), random_coord());
    end else begin
      seg = $urandom_range(0, NUM_SEGS - 1);
      if (seg < eff && !seg_ready(seg)) begin
        k = 3 * seg;
        while (loaded[k]) k++;
        write_point(k, random_coord(), random_coord(), random_coord());
      end else begin
        eval_curve(seg, random_t());
      end
    end
  endtask

  // Result side: random hold-offs, steady stretches and one long stall
  initial begin : drain
    int gap;
    int taken;
    out_ready = 1'b0;
    rx_steady = 1'b0;
    taken     = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      taken++;
      if (taken % 40 == 0)
        rx_steady = ($urandom_range(0, 3) == 0);
      // long stall so the block backs up into its input
      if (taken == 150) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
      end
    end
  end

  // Stimulus
  initial begin : stim
    int counts [7];
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_action        = ACT_WRITE;
    in_point_index   = '0;
    in_segment_index = '0;
    in_t_param       = '0;
    in_x             = '0;
    in_y             = '0;
    in_z             = '0;
    tx_steady        = 1'b0;
    cur_count        = 0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme coordinates on two segments
    load_count(2);
    write_point(0, C_MAX, C_MIN, '0);
    write_point(1, C_MIN, C_MAX, -32'sd1);
    write_point(2, '0, -32'sd1, C_MAX);
    write_point(3, -32'sd1, '0, C_MIN);
    write_point(4, 32'sh0001_0000, -32'sh0002_8000, 32'sh7FFF_0000);
    write_point(5, C_MAX, C_MAX, C_MAX);
    write_point(6, C_MIN, C_MIN, C_MIN);
    // slots past the store are ignored; the last slot is kept
    write_point(193, C_MAX, C_MAX, C_MAX);
    write_point(255, C_MIN, C_MIN, C_MIN);
    write_point(LAST_SLOT, 32'sh0000_8000, -32'sh0000_8000, 32'sh1234_5678);
    // end points, midpoint, smallest steps and parameters above one
    eval_curve(0, '0);
    eval_curve(0, ONE_Q16);
    eval_curve(0, 17'h1_FFFF);
    eval_curve(0, 17'h0_8000);
    eval_curve(0, 17'h0_0001);
    eval_curve(0, 17'h0_FFFF);
    eval_curve(1, 17'd21845);
    eval_curve(1, 17'h1_0001);
    // segments at and beyond the count
    eval_curve(2, 17'h0_4000);
    eval_curve(63, 17'h0_C000);

    // Random phases over a spread of counts, the extremes among them
    counts = '{64, 127, 0, 1, 17, $urandom_range(0, 127), 64};
    foreach (counts[ph]) begin
      load_count(counts[ph]);
      for (int i = 0; i < 300; i++) begin
        if (i % 50 == 0)
          tx_steady = ($urandom_range(0, 3) == 0);
        // one pause mid-phase until every curve point is back
        if (ph == 3 && i == 150)
          settle(0);
        random_item();
      end
    end

    settle(20);
    if (mismatches == 0 && points_due == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
